// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the polynomial unit.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that prop holds at every clock edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cond implies cons at the same clock edge.
`define CHK_IMPLY(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);
// Check that cond implies cons at the next clock edge.
`define CHK_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);
`else
`define CHK_ALWAYS(label, prop, msg)
`define CHK_IMPLY(label, cond, cons, msg)
`define CHK_NEXT(label, cond, cons, msg)
`endif
`endif

// ===== src/pasm_pkg.sv =====
// Shared sizes, operation codes and controller-to-datapath types
// for the polynomial add/subtract/multiply unit. No dependencies.
package pasm_pkg;

  // Store geometry and coefficient width
  localparam int MAX_DEG    = 31;
  localparam int COEFF_BITS = 16;
  localparam int DEPTH      = MAX_DEG + 1;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Fixed field widths of the ports
  localparam int FUNC_W  = 3;
  localparam int DEG_W   = 5;
  localparam int VALUE_W = 16;
  localparam int PW_W    = 6;
  localparam int RES_W   = 38;
  localparam int PROD_W  = 2 * COEFF_BITS;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SUB    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_MUL    = 3'd4;

  // Per-term flags that travel down the datapath pipeline
  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic              a_ok;
    logic              b_ok;
    logic              first;
    logic              term_last;
    logic              last_out;
    logic [PW_W-1:0]   power;
  } flg_t;

  // Command from controller to datapath
  typedef struct packed {
    logic          wr_a;
    logic          wr_b;
    logic          issue;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    flg_t          flg;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic adv;
  } stat_t;

endpackage

// ===== src/pasm_ctrl.sv =====
// Controller of the polynomial unit: accepts items, sequences term reads.
// Depends on pasm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pasm_ctrl import pasm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [DEG_W-1:0]    in_index,
  input  logic [DEG_W-1:0]    in_deg_a,
  input  logic [DEG_W-1:0]    in_deg_b,
  input  stat_t               stat,
  output cmd_t                cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic              state_r, state_nxt;
  logic [FUNC_W-1:0] op_r, op_nxt;
  logic [DEG_W-1:0]  da_r, da_nxt, db_r, db_nxt;
  logic [PW_W-1:0]   p_r, p_nxt;
  logic [DEG_W-1:0]  i_r, i_nxt;
  logic              first_r, first_nxt;

  logic              accept;
  logic              idx_ok;
  logic              is_compute;
  logic [DEG_W-1:0]  da_sat, db_sat;
  logic [PW_W-1:0]   da_x, db_x, p_last, p_inc, b_idx, lo_diff;
  logic [DEG_W-1:0]  i_hi, lo_next;
  logic              term_last;
  logic              issue;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_ok   = ({1'b0, in_index} <= PW_W'(MAX_DEG));
  assign da_sat   = ({1'b0, in_deg_a} > PW_W'(MAX_DEG)) ? DEG_W'(MAX_DEG) : in_deg_a;
  assign db_sat   = ({1'b0, in_deg_b} > PW_W'(MAX_DEG)) ? DEG_W'(MAX_DEG) : in_deg_b;

  // Decode the operation
  always_comb begin
    unique case (in_func) inside
      FUNC_ADD, FUNC_SUB, FUNC_MUL: is_compute = 1'b1;
      default:                      is_compute = 1'b0;
    endcase
  end

  // Term range for the current power
  assign da_x    = {1'b0, da_r};
  assign db_x    = {1'b0, db_r};
  assign p_last  = (op_r == FUNC_MUL) ? (da_x + db_x) : ((da_x > db_x) ? da_x : db_x);
  assign p_inc   = p_r + PW_W'(1);
  assign i_hi    = (p_r > da_x) ? da_r : p_r[DEG_W-1:0];
  assign lo_diff = p_inc - db_x;
  assign lo_next = (p_inc > db_x) ? lo_diff[DEG_W-1:0] : '0;
  assign b_idx   = p_r - {1'b0, i_r};
  assign term_last = (op_r == FUNC_MUL) ? (i_r == i_hi) : 1'b1;
  assign issue   = (state_r == S_RUN) && stat.adv;

  // Drive the datapath command
  always_comb begin
    cmd.wr_a          = accept && (in_func == FUNC_LOAD_A) && idx_ok;
    cmd.wr_b          = accept && (in_func == FUNC_LOAD_B) && idx_ok;
    cmd.issue         = issue;
    cmd.flg.op        = op_r;
    cmd.flg.power     = p_r;
    cmd.flg.term_last = term_last;
    cmd.flg.last_out  = term_last && (p_r == p_last);
    if (op_r == FUNC_MUL) begin
      cmd.addr_a    = i_r[AW-1:0];
      cmd.addr_b    = b_idx[AW-1:0];
      cmd.flg.a_ok  = 1'b1;
      cmd.flg.b_ok  = 1'b1;
      cmd.flg.first = first_r;
    end else begin
      cmd.addr_a    = p_r[AW-1:0];
      cmd.addr_b    = p_r[AW-1:0];
      cmd.flg.a_ok  = (p_r <= da_x);
      cmd.flg.b_ok  = (p_r <= db_x);
      cmd.flg.first = 1'b1;
    end
  end

  // Next state: latch a compute item, then walk powers and terms
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    da_nxt    = da_r;
    db_nxt    = db_r;
    p_nxt     = p_r;
    i_nxt     = i_r;
    first_nxt = first_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && is_compute) begin
          state_nxt = S_RUN;
          op_nxt    = in_func;
          da_nxt    = da_sat;
          db_nxt    = db_sat;
          p_nxt     = '0;
          i_nxt     = '0;
          first_nxt = 1'b1;
        end
      end
      S_RUN: begin
        if (issue) begin
          if (term_last) begin
            if (p_r == p_last) begin
              state_nxt = S_IDLE;
            end else begin
              p_nxt     = p_inc;
              i_nxt     = lo_next;
              first_nxt = 1'b1;
            end
          end else begin
            i_nxt     = i_r + DEG_W'(1);
            first_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Loop registers, no reset needed
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    da_r    <= da_nxt;
    db_r    <= db_nxt;
    p_r     <= p_nxt;
    i_r     <= i_nxt;
    first_r <= first_nxt;
  end

  `CHK_IMPLY(a_run_power_bound, state_r == S_RUN, p_r <= p_last, "power past last")
  `CHK_IMPLY(a_mul_term_bound, (state_r == S_RUN) && (op_r == FUNC_MUL), i_r <= i_hi,
    "term index past range")
  `CHK_NEXT(a_last_ends_run, issue && cmd.flg.last_out, state_r == S_IDLE,
    "run did not end after last term")

endmodule

// ===== src/pasm_dp.sv =====
// Datapath of the polynomial unit: coefficient stores, multiply/add stage,
// accumulator and output register. Depends on pasm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pasm_dp import pasm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [DEG_W-1:0]         in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PW_W-1:0]          out_power,
  output logic signed [RES_W-1:0]  out_result_coeff,
  output logic                     out_last
);

  logic signed [COEFF_BITS-1:0] mem_a [DEPTH];
  logic signed [COEFF_BITS-1:0] mem_b [DEPTH];

  logic signed [COEFF_BITS-1:0] wval;
  logic                         adv;

  logic                         s1_vld_r;
  flg_t                         s1_r;
  logic signed [COEFF_BITS-1:0] rd_a_r, rd_b_r;

  logic signed [COEFF_BITS-1:0] a_v, b_v;
  logic signed [PROD_W-1:0]     prod;
  logic signed [RES_W-1:0]      term_nxt;
  logic                         s2_vld_r;
  flg_t                         s2_r;
  logic signed [RES_W-1:0]      term_r;

  logic signed [RES_W-1:0]      acc_r, acc_nxt;
  logic                         out_valid_r;
  logic [PW_W-1:0]              out_power_r;
  logic signed [RES_W-1:0]      out_coeff_r;
  logic                         out_last_r;

  // Advance the whole pipeline unless a finished beat is stuck
  assign adv      = !out_valid_r || out_ready;
  assign stat.adv = adv;
  assign wval     = COEFF_BITS'(in_value);

  // Store A: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[in_index[AW-1:0]] <= wval;
    end
    if (adv) begin
      rd_a_r <= mem_a[cmd.addr_a];
    end
  end

  // Store B: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      mem_b[in_index[AW-1:0]] <= wval;
    end
    if (adv) begin
      rd_b_r <= mem_b[cmd.addr_b];
    end
  end

  // Mask missing terms and form the product, sum or difference
  assign a_v  = s1_r.a_ok ? rd_a_r : '0;
  assign b_v  = s1_r.b_ok ? rd_b_r : '0;
  assign prod = PROD_W'(a_v) * PROD_W'(b_v);

  always_comb begin
    case (s1_r.op)
      FUNC_MUL: term_nxt = RES_W'(prod);
      FUNC_SUB: term_nxt = RES_W'(a_v) - RES_W'(b_v);
      default:  term_nxt = RES_W'(a_v) + RES_W'(b_v);
    endcase
  end

  // Accumulate terms of one power
  assign acc_nxt = s2_r.first ? term_r : (acc_r + term_r);

  // Pipeline valid bits and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= cmd.issue;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r && s2_r.term_last;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= cmd.flg;
      s2_r   <= s1_r;
      term_r <= term_nxt;
      if (s2_vld_r) begin
        acc_r <= acc_nxt;
      end
      if (s2_vld_r && s2_r.term_last) begin
        out_power_r <= s2_r.power;
        out_coeff_r <= acc_nxt;
        out_last_r  <= s2_r.last_out;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_power        = out_power_r;
  assign out_result_coeff = out_coeff_r;
  assign out_last         = out_last_r;

  `CHK_NEXT(a_finish_shows, adv && s2_vld_r && s2_r.term_last, out_valid_r,
    "finished coefficient not shown")
  `CHK_NEXT(a_out_hold, out_valid_r && !out_ready,
    out_valid_r && $stable(out_power_r) && $stable(out_coeff_r) && $stable(out_last_r),
    "waiting beat changed")
  `CHK_IMPLY(a_write_idle, cmd.wr_a || cmd.wr_b, !cmd.issue, "store write during a run")

endmodule

// ===== src/polynomial_add_sub_mul_unit.sv =====
// A load writes its store at accept; compute terms pass the store read, compute and
// output registers. Throughput: unless the output stalls, add/subtract emit one beat a
// cycle, max(deg_a,deg_b)+1 beats; multiply forms one product a cycle, (deg_a+1)*(deg_b+1)
// products, set by the single multiplier and the one read port of each coefficient store.
// Reset: synchronous active-low rst_n clears the controller state and pipeline valids;
// the coefficient stores are not cleared.
module polynomial_add_sub_mul_unit import pasm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic [DEG_W-1:0]          in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [DEG_W-1:0]          in_deg_a,
  input  logic [DEG_W-1:0]          in_deg_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PW_W-1:0]           out_power,
  output logic signed [RES_W-1:0]   out_result_coeff,
  output logic                      out_last
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence items and terms
  pasm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .in_index (in_index),
    .in_deg_a (in_deg_a),
    .in_deg_b (in_deg_b),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, compute and deliver
  pasm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_index         (in_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_power        (out_power),
    .out_result_coeff (out_result_coeff),
    .out_last         (out_last)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for polynomial_add_sub_mul_unit: loads, add, subtract and
// multiply runs checked beat by beat against a coefficient-level predictor.
// Depends on pasm_pkg and the unit's RTL.
module tb import pasm_pkg::*; ();

  // Spare operation codes that the unit must ignore
  localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  localparam int CYCLE_LIMIT  = 2500000;
  localparam int TAIL_CYCLES  = 16;
  localparam int RANDOM_ITEMS = 350;
  localparam int QUIET_FROM   = 300;
  localparam int PLAN_ROWS    = 20;

  // One coefficient of a result run
  typedef struct packed {
    logic [PW_W-1:0]         power;
    logic signed [RES_W-1:0] coeff;
    logic                    last;
  } term_t;

  // One row of the directed stimulus table
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [DEG_W-1:0]   index;
    logic [VALUE_W-1:0] value;
    logic [DEG_W-1:0]   deg_a;
    logic [DEG_W-1:0]   deg_b;
    logic               typed;
    logic [RES_W-1:0]   coeff;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [FUNC_W-1:0]         in_func = '0;
  logic [DEG_W-1:0]          in_index = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic [DEG_W-1:0]          in_deg_a = '0;
  logic [DEG_W-1:0]          in_deg_b = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [PW_W-1:0]           out_power;
  logic signed [RES_W-1:0]   out_result_coeff;
  logic                      out_last;

  logic signed [COEFF_BITS-1:0] coef_a [DEPTH];
  logic signed [COEFF_BITS-1:0] coef_b [DEPTH];
  term_t     pending_terms [$];
  plan_row_t plan [PLAN_ROWS];
  term_t     want;
  int        errors = 0;
  int        cycle_count = 0;
  int        ready_left = 0;
  bit        quiet = 1'b0;

  polynomial_add_sub_mul_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_index         (in_index),
    .in_value         (in_value),
    .in_deg_a         (in_deg_a),
    .in_deg_b         (in_deg_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_power        (out_power),
    .out_result_coeff (out_result_coeff),
    .out_last         (out_last)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_count,
               pending_terms.size());
      $display("[polynomial_add_sub_mul_unit] ERROR");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  // Update the stores for a load, or queue the coefficients a compute item yields
  task automatic predict_terms(input logic [FUNC_W-1:0] f, input logic [DEG_W-1:0] ix,
                               input logic signed [VALUE_W-1:0] v,
                               input logic [DEG_W-1:0] da, input logic [DEG_W-1:0] db);
    int    na = int'(da);
    int    nb = int'(db);
    int    n;
    longint va;
    longint vb;
    longint acc;
    term_t t;
    case (f) inside
      FUNC_LOAD_A: coef_a[ix] = COEFF_BITS'(v);
      FUNC_LOAD_B: coef_b[ix] = COEFF_BITS'(v);
      FUNC_ADD, FUNC_SUB: begin
        n = ((na > nb) ? na : nb) + 1;
        for (int p = 0; p < n; p++) begin
          // missing terms count as zero
          va = (p <= na) ? longint'(coef_a[p]) : 64'sd0;
          vb = (p <= nb) ? longint'(coef_b[p]) : 64'sd0;
          t.power = p[PW_W-1:0];
          t.coeff = RES_W'((f == FUNC_ADD) ? va + vb : va - vb);
          t.last  = (p == n - 1);
          pending_terms.push_back(t);
        end
      end
      FUNC_MUL: begin
        n = na + nb + 1;
        for (int p = 0; p < n; p++) begin
          acc = 0;
          for (int i = 0; i <= na; i++) begin
            if (p >= i && p - i <= nb)
              acc += longint'(coef_a[i]) * longint'(coef_b[p - i]);
          end
          t.power = p[PW_W-1:0];
          t.coeff = RES_W'(acc);
          t.last  = (p == n - 1);
          pending_terms.push_back(t);
        end
      end
      default: ;
    endcase
  endtask

  // Present one beat, hold it until accepted, then record what it should yield
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [DEG_W-1:0] ix,
                           input logic signed [VALUE_W-1:0] v,
                           input logic [DEG_W-1:0] da, input logic [DEG_W-1:0] db,
                           input bit typed, input logic signed [RES_W-1:0] coeff);
    term_t t;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_index <= ix;
    in_value <= v;
    in_deg_a <= da;
    in_deg_b <= db;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) begin
      t.power = '0;
      t.coeff = coeff;
      t.last  = 1'b1;
      pending_terms.push_back(t);
    end else begin
      predict_terms(f, ix, v, da, db);
    end
  endtask

  // Hold the sender off until every queued beat has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_terms.size() != 0) @(posedge clk);
  endtask

  // Receiver: alternate ready runs with stall bursts, always ready when quiet
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      ready_left <= $urandom_range(0, 10);
    end else begin
      out_ready  <= 1'b1;
      ready_left <= $urandom_range(0, 19);
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_terms.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat power %0d coeff %0d last %0d",
                                out_power, out_result_coeff, out_last));
      end else begin
        want = pending_terms.pop_front();
        if (out_power !== want.power)
          flag_mismatch($sformatf("power %0d, want %0d", out_power, want.power));
        if (out_result_coeff !== want.coeff)
          flag_mismatch($sformatf("coeff %0d at power %0d, want %0d",
                                  out_result_coeff, want.power, want.coeff));
        if (out_last !== want.last)
          flag_mismatch($sformatf("last %0d at power %0d, want %0d",
                                  out_last, want.power, want.last));
      end
    end
  end

  initial begin
    int counted;
    int pick;
    logic [FUNC_W-1:0]         f;
    logic [DEG_W-1:0]          ix;
    logic signed [VALUE_W-1:0] v;
    logic [DEG_W-1:0]          da;
    logic [DEG_W-1:0]          db;

    // Directed table: extremes, every operation, missing terms, spare codes
    plan[0]  = '{FUNC_LOAD_A, 5'd0, 16'h7FFF, 5'd0, 5'd0, 1'b0, '0};
    plan[1]  = '{FUNC_LOAD_B, 5'd0, 16'h8000, 5'd0, 5'd0, 1'b0, '0};
    plan[2]  = '{FUNC_ADD, 5'd0, 16'h0000, 5'd0, 5'd0, 1'b1, -38'sd1};
    plan[3]  = '{FUNC_SUB, 5'd0, 16'h0000, 5'd0, 5'd0, 1'b1, 38'sd65535};
    plan[4]  = '{FUNC_MUL, 5'd0, 16'h0000, 5'd0, 5'd0, 1'b1, -38'sd1073709056};
    plan[5]  = '{FUNC_LOAD_A, 5'd0, 16'h8000, 5'd0, 5'd0, 1'b0, '0};
    plan[6]  = '{FUNC_MUL, 5'd0, 16'h0000, 5'd0, 5'd0, 1'b1, 38'sd1073741824};
    plan[7]  = '{FUNC_SUB, 5'd0, 16'h0000, 5'd0, 5'd0, 1'b1, 38'sd0};
    plan[8]  = '{FUNC_LOAD_A, 5'd1, 16'h1234, 5'd0, 5'd0, 1'b0, '0};
    plan[9]  = '{FUNC_LOAD_B, 5'd1, 16'hFFFF, 5'd0, 5'd0, 1'b0, '0};
    plan[10] = '{FUNC_LOAD_A, 5'd2, 16'hAAAA, 5'd0, 5'd0, 1'b0, '0};
    plan[11] = '{FUNC_LOAD_B, 5'd2, 16'h5555, 5'd0, 5'd0, 1'b0, '0};
    plan[12] = '{FUNC_ADD, 5'd0, 16'h0000, 5'd2, 5'd1, 1'b0, '0};
    plan[13] = '{FUNC_SUB, 5'd0, 16'h0000, 5'd1, 5'd2, 1'b0, '0};
    plan[14] = '{FUNC_MUL, 5'd0, 16'h0000, 5'd2, 5'd2, 1'b0, '0};
    plan[15] = '{FUNC_MUL, 5'd0, 16'h0000, 5'd0, 5'd2, 1'b0, '0};
    plan[16] = '{FUNC_SPARE_5, 5'd31, 16'hFFFF, 5'd31, 5'd31, 1'b0, '0};
    plan[17] = '{FUNC_SPARE_6, 5'd0, 16'h7FFF, 5'd31, 5'd0, 1'b0, '0};
    plan[18] = '{FUNC_SPARE_7, 5'd0, 16'h8000, 5'd0, 5'd31, 1'b0, '0};
    plan[19] = '{FUNC_ADD, 5'd0, 16'h0000, 5'd0, 5'd0, 1'b1, -38'sd65536};

    // Hold reset low, then release it
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int r = 0; r < PLAN_ROWS; r++)
      send_item(plan[r].func, plan[r].index, plan[r].value, plan[r].deg_a, plan[r].deg_b,
                plan[r].typed, plan[r].coeff);
    drain_results();

    // Fill both stores so that any degree reads written entries only
    for (int i = 0; i < DEPTH; i++) begin
      send_item(FUNC_LOAD_A, i[DEG_W-1:0], VALUE_W'($urandom), DEG_W'($urandom),
                DEG_W'($urandom), 1'b0, '0);
      send_item(FUNC_LOAD_B, i[DEG_W-1:0], VALUE_W'($urandom), DEG_W'($urandom),
                DEG_W'($urandom), 1'b0, '0);
    end

    // Random mix of loads and computes, mostly small degrees
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted == QUIET_FROM)
        quiet = 1'b1;
      if (counted % 120 == 119)
        drain_results();
      ix = DEG_W'($urandom);
      da = DEG_W'($urandom);
      db = DEG_W'($urandom);
      v  = VALUE_W'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        f = ($urandom_range(0, 1) == 0) ? FUNC_LOAD_A : FUNC_LOAD_B;
        counted++;
      end else if (pick < 40) begin
        f = FUNC_W'(FUNC_SPARE_5 + $urandom_range(0, 2));
      end else begin
        case ($urandom_range(0, 2))
          0: f = FUNC_ADD;
          1: f = FUNC_SUB;
          default: f = FUNC_MUL;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          da = DEG_W'($urandom_range(0, 5));
          db = DEG_W'($urandom_range(0, 5));
        end else if (pick >= 95) begin
          da = DEG_W'(MAX_DEG);
          db = DEG_W'(MAX_DEG);
        end
        counted++;
      end
      send_item(f, ix, v, da, db, 1'b0, '0);
    end

    // Wait out every due beat, then a short tail for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[polynomial_add_sub_mul_unit] OK");
    else
      $display("[polynomial_add_sub_mul_unit] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/pasm_pkg.sv
src/pasm_ctrl.sv
src/pasm_dp.sv
src/polynomial_add_sub_mul_unit.sv
sim/tb.sv
